// File: hw/rtl/lds_pkg.sv
// Shared types and constants for the LCG discrete sampler.
// No dependencies; imported by lds_out, lds_ctrl, the top level and the bench.
package lds_pkg;

	localparam int TableDepthDef = 256;

	localparam logic [31:0] LcgMul = 32'd69069;
	localparam logic [31:0] LcgAdd = 32'd1;

	// Halving stops once the window spans this many entries or fewer.
	localparam logic [31:0] ScanSpan = 32'd4;

	localparam logic [8:0] TableSizeRst = 9'd1;

	// Request kinds
	localparam logic [1:0] KIND_RESEED = 2'd0;
	localparam logic [1:0] KIND_LOAD   = 2'd1;
	localparam logic [1:0] KIND_TABLE  = 2'd2;
	localparam logic [1:0] KIND_UNIF   = 2'd3;

	typedef struct packed {
		logic [31:0] drawn;
		logic [31:0] state;
		logic        err;
	} res_t;

endpackage

// File: hw/rtl/lds_mem.sv
// Single-port weight table memory with a registered read.
// Depends on nothing but its parameter.
module lds_mem #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      en,
	input  logic                                      we,
	input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] addr,
	input  logic [31:0]                               wdata,
	output logic [31:0]                               rdata
);
	logic [31:0] mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: hw/rtl/lds_out.sv
// Output register: holds one result until the receiver takes it.
// Depends on lds_pkg (res_t).
module lds_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  lds_pkg::res_t res,
	output logic          free,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [31:0]   drawn_value,
	output logic [31:0]   state_now,
	output logic          range_error
);
	import lds_pkg::*;

	logic out_valid_q;
	res_t res_q;

	assign free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign drawn_value = res_q.drawn;
	assign state_now   = res_q.state;
	assign range_error = res_q.err;

endmodule

// File: hw/rtl/lds_ctrl.sv
// Sequencer: generator state, shared multiplier, table search and uniform draw.
// Depends on lds_pkg; drives the table memory in lds_mem.
module lds_ctrl #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    kind,
	input  logic [7:0]    entry_index,
	input  logic [31:0]   word_value,
	input  logic [31:0]   low_bound,
	input  logic [31:0]   high_bound,
	input  logic          cfg_valid,
	input  logic [8:0]    table_size,
	input  logic          out_free,
	output logic          res_valid,
	output lds_pkg::res_t res,
	output logic          mem_en,
	output logic          mem_we,
	output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] mem_addr,
	output logic [31:0]   mem_wdata,
	input  logic [31:0]   mem_rdata
);
	import lds_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_TOT    = 3'd1;
	localparam logic [2:0] S_LAUNCH = 3'd2;
	localparam logic [2:0] S_CMP    = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_UMUL   = 3'd5;
	localparam logic [2:0] S_UADD   = 3'd6;
	localparam logic [2:0] S_DONE   = 3'd7;

	logic [2:0]    st_q;
	logic [31:0]   state_q;
	logic [8:0]    table_size_q;
	logic [IW-1:0] last_q, lo_q, hi_q, mid_q, idx_q;
	logic [31:0]   diff_q, low_q, drawn_q;
	logic          err_q;
	logic [63:0]   prod_q;

	logic          accept;
	logic [31:0]   adv;
	logic [IW-1:0] last_n;
	logic          load_ok;
	logic          below;
	logic [IW-1:0] win_lo, win_hi, win_span, win_mid;
	logic          win_wide;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [63:0]   unif_sum;

	assign accept = in_valid && in_ready;
	assign in_ready = (st_q == S_IDLE);
	assign adv = state_q * LcgMul + LcgAdd;

	// Clamp table_size to [1, TABLE_DEPTH] and take the last index in use.
	always_comb begin
		if (table_size_q == 9'd0) begin
			last_n = '0;
		end else if (32'(table_size_q) > 32'(TABLE_DEPTH)) begin
			last_n = IW'(TABLE_DEPTH - 1);
		end else begin
			last_n = IW'(table_size_q - 9'd1);
		end
	end

	assign load_ok = 32'(entry_index) < 32'(TABLE_DEPTH);

	// entry*2^32 < s*total, with the product held in prod_q
	assign below = (mem_rdata < prod_q[63:32]) ||
		((mem_rdata == prod_q[63:32]) && (prod_q[31:0] != 32'd0));

	// Window for the next probe: the full table on launch, else the narrowed one.
	always_comb begin
		if (st_q == S_CMP) begin
			win_lo = below ? mid_q : lo_q;
			win_hi = below ? hi_q : mid_q;
		end else begin
			win_lo = '0;
			win_hi = last_q;
		end
	end
	assign win_span = win_hi - win_lo;
	assign win_wide = 32'(win_span) > ScanSpan;
	assign win_mid  = win_lo + (win_span >> 1);

	// One multiplier serves both the draw target and the uniform scaling.
	assign mul_b = (st_q == S_TOT) ? mem_rdata : diff_q;
	assign mul_p = state_q * mul_b;
	assign unif_sum = prod_q + {32'd0, state_q};

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = word_value;
		unique case (st_q)
			S_IDLE: begin
				if (accept && kind == KIND_LOAD && load_ok) begin
					mem_en   = 1'b1;
					mem_we   = 1'b1;
					mem_addr = IW'(entry_index);
				end else if (accept && kind == KIND_TABLE) begin
					mem_en   = 1'b1;
					mem_addr = last_n;
				end
			end
			S_LAUNCH, S_CMP: begin
				mem_en   = 1'b1;
				mem_addr = win_wide ? win_mid : win_lo;
			end
			S_SCAN: begin
				mem_en   = 1'b1;
				mem_addr = idx_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	assign res_valid = (st_q == S_DONE) && out_free;
	assign res.drawn = drawn_q;
	assign res.state = state_q;
	assign res.err   = err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			state_q      <= 32'd0;
			table_size_q <= TableSizeRst;
		end else begin
			if (cfg_valid) begin
				table_size_q <= table_size;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						unique case (kind)
							KIND_RESEED: begin
								state_q <= word_value;
								st_q    <= S_DONE;
							end
							KIND_LOAD: st_q <= S_DONE;
							KIND_TABLE: begin
								state_q <= adv;
								st_q    <= S_TOT;
							end
							KIND_UNIF: begin
								if ($signed(high_bound) < $signed(low_bound)) begin
									st_q <= S_DONE;
								end else begin
									state_q <= adv;
									st_q    <= S_UMUL;
								end
							end
							default: st_q <= S_DONE;
						endcase
					end
				end
				S_TOT:    st_q <= S_LAUNCH;
				S_LAUNCH: st_q <= win_wide ? S_CMP : S_SCAN;
				S_CMP:    st_q <= win_wide ? S_CMP : S_SCAN;
				S_SCAN: begin
					if (!(idx_q != last_q && below)) begin
						st_q <= S_DONE;
					end
				end
				S_UMUL:   st_q <= S_UADD;
				S_UADD:   st_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						st_q <= S_IDLE;
					end
				end
				default:  st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				last_q  <= last_n;
				low_q   <= low_bound;
				diff_q  <= high_bound - low_bound;
				drawn_q <= (kind == KIND_UNIF) ? low_bound : 32'd0;
				err_q   <= (kind == KIND_UNIF) && ($signed(high_bound) < $signed(low_bound));
			end
			S_TOT: begin
				prod_q <= mul_p;
			end
			S_LAUNCH, S_CMP: begin
				lo_q  <= win_lo;
				hi_q  <= win_hi;
				mid_q <= win_mid;
				idx_q <= win_lo;
			end
			S_SCAN: begin
				if (idx_q != last_q && below) begin
					idx_q <= idx_q + IW'(1);
				end else begin
					drawn_q <= 32'(idx_q);
				end
			end
			S_UMUL: begin
				prod_q <= mul_p;
			end
			S_UADD: begin
				drawn_q <= low_q + unif_sum[63:32];
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hw/rtl/lcg_discrete_sampler_unit.sv
// LCG discrete sampler, top level.
// Request channel: in_valid/in_ready with kind, entry_index, word_value,
// low_bound, high_bound. Result channel: out_valid/out_ready with
// drawn_value, state_now, range_error. One result per request, in order.
// Config channel: cfg_valid/cfg_ready with table_size; always ready.
// Write it only while no request is in flight.
// Steps from request accept to result valid, with the receiver ready:
//   reseed, load, inverted-range uniform draw: straight to the result
//   uniform draw: generator step, 32x32 multiply, add
//   table draw: total read, multiply, halving probes of the window and
//   scan reads (within the last window on a nondecreasing table, up to the
//   last entry in use otherwise), one table memory read per cycle on its one port.
// One request is worked on at a time; the next is accepted the cycle after
// the result moves into the output register.
// Reset clears the generator state to zero, table_size to 1 and the output
// valid flag, not the result register; table contents are undefined until loaded.
// When the receiver stalls, the result waits in the output register and the
// block takes and works one more request, then holds its result until the
// output register frees.
// Depends on lds_pkg, lds_ctrl, lds_mem, lds_out.
module lcg_discrete_sampler_unit #(
	parameter int TABLE_DEPTH = lds_pkg::TableDepthDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  entry_index,
	input  logic [31:0] word_value,
	input  logic [31:0] low_bound,
	input  logic [31:0] high_bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] drawn_value,
	output logic [31:0] state_now,
	output logic        range_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  table_size
);
	import lds_pkg::*;

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	logic          out_free;
	logic          res_valid;
	res_t          res;
	logic          mem_en, mem_we;
	logic [IW-1:0] mem_addr;
	logic [31:0]   mem_wdata, mem_rdata;

	assign cfg_ready = 1'b1;

	lds_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .entry_index(entry_index), .word_value(word_value),
		.low_bound(low_bound), .high_bound(high_bound),
		.cfg_valid(cfg_valid), .table_size(table_size),
		.out_free(out_free), .res_valid(res_valid), .res(res),
		.mem_en(mem_en), .mem_we(mem_we), .mem_addr(mem_addr),
		.mem_wdata(mem_wdata), .mem_rdata(mem_rdata)
	);

	lds_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
		.clk(clk), .en(mem_en), .we(mem_we), .addr(mem_addr),
		.wdata(mem_wdata), .rdata(mem_rdata)
	);

	lds_out u_out (
		.clk(clk), .arst_n(arst_n),
		.res_valid(res_valid), .res(res), .free(out_free),
		.out_valid(out_valid), .out_ready(out_ready),
		.drawn_value(drawn_value), .state_now(state_now),
		.range_error(range_error)
	);

endmodule

// File: hw/rtl/lds_checker.sv
// Port-level checks for lcg_discrete_sampler_unit, bound to the top level.
// Depends only on the top level's ports.
module lds_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] drawn_value,
	input logic [31:0] state_now,
	input logic        range_error
);

	// A request taken keeps the block busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after a request was accepted");

	// A new result only shows up out of a busy cycle.
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in flight");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(drawn_value) &&
			$stable(state_now) && $stable(range_error)))
		else $error("stalled result changed or dropped");

endmodule

bind lcg_discrete_sampler_unit lds_checker u_lds_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.drawn_value(drawn_value), .state_now(state_now),
	.range_error(range_error)
);

// File: tb/lcg_discrete_sampler_unit_tb.sv
// Self-checking bench for lcg_discrete_sampler_unit: queued requests, a predictor of the
// generator and table sampler, and a result checker with random stalls on both channels.
// Depends on lds_pkg and the RTL of the block only.
module lcg_discrete_sampler_unit_tb;
	import lds_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int SettleCycles = 8;
	localparam int ShadowDepth  = TableDepthDef;

	typedef struct {
		logic        is_cfg;
		logic [8:0]  cfg_val;
		logic [1:0]  kind;
		logic [7:0]  idx;
		logic [31:0] word;
		logic [31:0] lo;
		logic [31:0] hi;
	} sample_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  kind = '0;
	logic [7:0]  entry_index = '0;
	logic [31:0] word_value = '0;
	logic [31:0] low_bound = '0;
	logic [31:0] high_bound = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] drawn_value;
	logic [31:0] state_now;
	logic        range_error;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [8:0]  table_size = '0;

	// predictor state
	logic [31:0] lcg_shadow;
	logic [31:0] cdf_shadow [ShadowDepth];
	logic [8:0]  size_shadow;

	sample_req_t pend_q[$];
	res_t        draw_exp_q[$];

	bit in_fire = 1'b0;
	bit cfg_fire = 1'b0;
	int cycles = 0;
	int n_acc = 0;
	int n_res = 0;
	int quiet_cycles = 0;
	int mismatches = 0;
	int hold_left = 0;
	bit long_hold_done = 1'b0;
	logic calm;

	assign calm = (n_acc >= 560) && (n_acc < 700);

	lcg_discrete_sampler_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.entry_index (entry_index),
		.word_value  (word_value),
		.low_bound   (low_bound),
		.high_bound  (high_bound),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drawn_value (drawn_value),
		.state_now   (state_now),
		.range_error (range_error),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.table_size  (table_size)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] lcg_advance();
		lcg_shadow = lcg_shadow * LcgMul + LcgAdd;
		return lcg_shadow;
	endfunction

	// entry < s*total/2^32, exact in 64 bits
	function automatic bit under_target(input logic [31:0] entry, input logic [31:0] s,
			input logic [31:0] total);
		logic [63:0] lhs;
		logic [63:0] rhs;
		lhs = {entry, 32'd0};
		rhs = {32'd0, s} * {32'd0, total};
		return lhs < rhs;
	endfunction

	function automatic res_t predict_sample(input logic [1:0] k, input logic [7:0] idx,
			input logic [31:0] w, input logic [31:0] lo, input logic [31:0] hi);
		res_t        res;
		int          n, lo_i, hi_i, mid, i;
		logic [31:0] s, total, lo_b, hi_b;
		logic [32:0] span;
		logic [64:0] prod;
		res = '0;
		case (k)
			KIND_RESEED: begin
				lcg_shadow = w;
			end
			KIND_LOAD: begin
				cdf_shadow[idx] = w;
			end
			KIND_TABLE: begin
				n = int'(size_shadow);
				if (n < 1) n = 1;
				if (n > ShadowDepth) n = ShadowDepth;
				s = lcg_advance();
				total = cdf_shadow[n-1];
				lo_i = 0;
				hi_i = n - 1;
				while (hi_i - lo_i > 4) begin
					mid = lo_i + (hi_i - lo_i) / 2;
					if (under_target(cdf_shadow[mid], s, total)) lo_i = mid;
					else hi_i = mid;
				end
				i = lo_i;
				while (i < n - 1 && under_target(cdf_shadow[i], s, total)) i++;
				res.drawn = 32'(i);
			end
			default: begin
				lo_b = lo ^ 32'h8000_0000;
				hi_b = hi ^ 32'h8000_0000;
				if (hi_b < lo_b) begin
					res.err = 1'b1;
					res.drawn = lo;
				end else begin
					span = {1'b0, hi_b - lo_b} + 33'd1;
					s = lcg_advance();
					prod = {33'd0, s} * {32'd0, span};
					res.drawn = lo + prod[63:32];
				end
			end
		endcase
		res.state = lcg_shadow;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= 60)
			$display("mismatch on %s at result %0d: got %h, want %h", what, n_res, got, want);
	endtask

	function automatic sample_req_t make_req(input logic [1:0] k, input logic [7:0] idx,
			input logic [31:0] w, input logic [31:0] lo, input logic [31:0] hi);
		sample_req_t r;
		r.is_cfg = 1'b0;
		r.cfg_val = '0;
		r.kind = k;
		r.idx = idx;
		r.word = w;
		r.lo = lo;
		r.hi = hi;
		return r;
	endfunction

	task automatic queue_cfg(input logic [8:0] v);
		sample_req_t r;
		r = make_req(KIND_RESEED, '0, '0, '0, '0);
		r.is_cfg = 1'b1;
		r.cfg_val = v;
		pend_q.push_back(r);
	endtask

	// Mostly draws; loads keep the table roughly monotone in the top byte.
	task automatic queue_random(input int count);
		sample_req_t r;
		int          pick, m;
		for (int c = 0; c < count; c++) begin
			pick = $urandom_range(0, 99);
			r = make_req(KIND_UNIF, 8'($urandom), $urandom, $urandom, $urandom);
			if (pick < 6) begin
				r.kind = KIND_RESEED;
			end else if (pick < 18) begin
				r.kind = KIND_LOAD;
				if ($urandom_range(0, 2) != 0) r.word = {r.idx, 24'($urandom)};
			end else if (pick < 58) begin
				r.kind = KIND_TABLE;
			end else begin
				m = $urandom_range(0, 99);
				if (m < 55) r.hi = r.lo + 32'($urandom_range(0, 1000));
				else if (m < 65) r.hi = r.lo;
				else if (m < 72) begin
					r.lo = 32'h8000_0000;
					r.hi = 32'h7FFF_FFFF;
				end
			end
			pend_q.push_back(r);
		end
	endtask

	// Request driver: holds a request until taken; config waits for a drained block.
	always @(negedge clk) begin : req_driver
		sample_req_t head;
		logic        nv, ncv;
		if (!arst_n) begin
			in_valid <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nv = in_valid && !in_fire;
			ncv = cfg_valid && !cfg_fire;
			if (!nv && !ncv && pend_q.size() > 0) begin
				head = pend_q[0];
				if (head.is_cfg) begin
					if (draw_exp_q.size() == 0 && quiet_cycles >= SettleCycles) begin
						ncv = 1'b1;
						table_size <= head.cfg_val;
						void'(pend_q.pop_front());
					end
				end else if (calm || $urandom_range(0, 99) >= 38) begin
					nv = 1'b1;
					kind <= head.kind;
					entry_index <= head.idx;
					word_value <= head.word;
					low_bound <= head.lo;
					high_bound <= head.hi;
					void'(pend_q.pop_front());
				end
			end
			in_valid <= nv;
			cfg_valid <= ncv;
		end
	end

	// Result sink: random stalls plus one long hold-off while requests keep coming.
	always @(negedge clk) begin : result_sink
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!long_hold_done && n_acc >= 400) begin
			long_hold_done = 1'b1;
			hold_left = 299;
			out_ready <= 1'b0;
		end else begin
			out_ready <= calm || ($urandom_range(0, 99) >= 38);
		end
	end

	always @(posedge clk) begin : result_monitor
		res_t want;
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end else if (arst_n) begin
			if (out_valid && out_ready) begin
				n_res++;
				if (draw_exp_q.size() == 0) begin
					report_mismatch("unexpected result", drawn_value, '0);
				end else begin
					want = draw_exp_q.pop_front();
					if (drawn_value !== want.drawn)
						report_mismatch("drawn_value", drawn_value, want.drawn);
					if (state_now !== want.state)
						report_mismatch("state_now", state_now, want.state);
					if (range_error !== want.err)
						report_mismatch("range_error", 32'(range_error), 32'(want.err));
				end
			end
			in_fire = in_valid && in_ready;
			cfg_fire = cfg_valid && cfg_ready;
			if (cfg_fire) size_shadow = table_size;
			if (in_fire) begin
				draw_exp_q.push_back(predict_sample(kind, entry_index, word_value,
					low_bound, high_bound));
				n_acc++;
			end
			if (draw_exp_q.size() == 0 && !out_valid) quiet_cycles++;
			else quiet_cycles = 0;
		end
	end

	initial begin : stimulus
		lcg_shadow = '0;
		size_shadow = TableSizeRst;
		foreach (cdf_shadow[j]) cdf_shadow[j] = '0;

		queue_cfg(9'd1);
		pend_q.push_back(make_req(KIND_RESEED, 8'd0, 32'd0, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'd0, 32'd0));
		// zero total, then a full-scale single entry
		pend_q.push_back(make_req(KIND_LOAD, 8'd0, 32'd0, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_TABLE, 8'd0, 32'd0, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_TABLE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pend_q.push_back(make_req(KIND_RESEED, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'h8000_0000, 32'h8000_0000));
		// inverted ranges: flagged, low returned, generator untouched
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'd5, 32'd4));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'd0, 32'hFFFF_FFFF));
		pend_q.push_back(make_req(KIND_LOAD, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_LOAD, 8'hAA, 32'd0, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_LOAD, 8'h55, 32'hAAAA_AAAA, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_RESEED, 8'd0, 32'h5555_5555, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_TABLE, 8'd0, 32'd0, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, -32'sd10, 32'sd10));
		pend_q.push_back(make_req(KIND_RESEED, 8'd0, 32'h8000_0000, 32'd0, 32'd0));
		pend_q.push_back(make_req(KIND_UNIF, 8'd0, 32'd0, 32'hFFFF_FFFF, 32'd0));

		// fill the whole table, monotone, so any size reads written entries only
		for (int k = 0; k < ShadowDepth; k++)
			pend_q.push_back(make_req(KIND_LOAD, 8'(k), {8'(k), 24'($urandom)},
				$urandom, $urandom));

		queue_cfg(9'd256);
		queue_random(100);
		queue_cfg(9'd0);
		queue_random(60);
		queue_cfg(9'h1FF);
		queue_random(80);
		queue_cfg(9'd5);
		queue_random(60);
		queue_cfg(9'd6);
		// descending table: scan must stop at the last entry in use
		for (int k = 0; k < 6; k++)
			pend_q.push_back(make_req(KIND_LOAD, 8'(k), 32'hFFFF_FFFF - 32'(k) * 32'h1000_0000,
				32'd0, 32'd0));
		for (int k = 0; k < 4; k++)
			pend_q.push_back(make_req(KIND_TABLE, 8'd0, 32'd0, 32'd0, 32'd0));
		queue_random(60);
		queue_cfg(9'd2);
		queue_random(60);
		queue_cfg(9'($urandom_range(1, 256)));
		queue_random(50);
		queue_cfg(9'($urandom));
		queue_random(50);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pend_q.size() != 0 || in_valid || cfg_valid || draw_exp_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lds_pkg.sv
hw/rtl/lds_mem.sv
hw/rtl/lds_out.sv
hw/rtl/lds_ctrl.sv
hw/rtl/lcg_discrete_sampler_unit.sv
hw/rtl/lds_checker.sv
tb/lcg_discrete_sampler_unit_tb.sv
